/* hdl/dus_pkg.sv */
package dus_pkg;

    localparam logic [1:0] F_ADD  = 2'd0;
    localparam logic [1:0] F_REM  = 2'd1;
    localparam logic [1:0] F_HINT = 2'd2;
    localparam logic [1:0] F_TICK = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_USED   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DISP = 1'b1;

    localparam logic [15:0] LO_FLOOR = 16'd30;
    localparam logic [15:0] BASE_MS  = 16'd1000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_SEARCH,
        S_CALC1,
        S_CALC2
    } state_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_ADD,
        UPD_FREE,
        UPD_HINT,
        UPD_FIRE,
        UPD_DROP,
        UPD_CLR
    } upd_op_t;

    // Update broadcast from the controller to every cell.
    typedef struct packed {
        upd_op_t     op;
        logic [31:0] deadline;
        logic [31:0] last_run;
        logic [15:0] min_ms;
        logic [15:0] max_ms;
        logic [9:0]  scale;
        logic        wanted;
    } upd_t;

    // Best due entry so far, passed from cell to cell.
    typedef struct packed {
        logic        vld;
        logic [31:0] deadline;
        logic [31:0] last_run;
        logic [15:0] min_ms;
        logic [15:0] max_ms;
        logic [9:0]  scale;
        logic        wanted;
    } cand_t;

endpackage

/* hdl/dus_cell.sv */
module dus_cell
    import dus_pkg::*;
#(
    parameter int IDW = 5,
    parameter int IDX = 0
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    now,
    input  upd_t           upd,
    input  logic [IDW-1:0] upd_id,
    input  cand_t          cin,
    input  logic [IDW-1:0] cin_id,
    output cand_t          cout,
    output logic [IDW-1:0] cout_id,
    output logic           used
);

    logic        valid_reg, valid_next;
    logic        fired_reg, fired_next;
    logic [31:0] dl_reg, last_reg;
    logic [15:0] min_reg, max_reg;
    logic [9:0]  scale_reg;
    logic        want_reg;
    cand_t          cout_reg, cout_next;
    logic [IDW-1:0] id_reg, id_next;
    logic        hit, due, take;

    assign hit  = (upd_id == IDW'(IDX));
    assign due  = valid_reg && !fired_reg && (dl_reg < now);
    // Lower slots sit earlier in the row, so a tie keeps the incoming word.
    assign take = due && (!cin.vld || (dl_reg < cin.deadline));

    always_comb
    begin
        valid_next = valid_reg;
        fired_next = fired_reg;
        if (upd.op == UPD_CLR)
        begin
            fired_next = 1'b0;
        end
        else if (hit)
        begin
            case (upd.op)
                UPD_ADD:  valid_next = 1'b1;
                UPD_FREE: valid_next = 1'b0;
                UPD_FIRE: fired_next = 1'b1;
                UPD_DROP:
                begin
                    valid_next = 1'b0;
                    fired_next = 1'b1;
                end
                default: ;
            endcase
        end
        if (take)
        begin
            cout_next = '{vld: 1'b1, deadline: dl_reg, last_run: last_reg,
                          min_ms: min_reg, max_ms: max_reg, scale: scale_reg,
                          wanted: want_reg};
            id_next   = IDW'(IDX);
        end
        else
        begin
            cout_next = cin;
            id_next   = cin_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fired_reg <= 1'b0;
            cout_reg  <= '0;
            id_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            fired_reg <= fired_next;
            cout_reg  <= cout_next;
            id_reg    <= id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && upd.op == UPD_ADD)
        begin
            dl_reg    <= upd.deadline;
            last_reg  <= upd.last_run;
            min_reg   <= upd.min_ms;
            max_reg   <= upd.max_ms;
            scale_reg <= upd.scale;
            want_reg  <= upd.wanted;
        end
        else if (hit && upd.op == UPD_HINT)
        begin
            scale_reg <= upd.scale;
            want_reg  <= upd.wanted;
        end
        else if (hit && upd.op == UPD_FIRE)
        begin
            dl_reg   <= upd.deadline;
            last_reg <= upd.last_run;
        end
    end

    assign cout    = cout_reg;
    assign cout_id = id_reg;
    assign used    = valid_reg;

endmodule

/* hdl/deadline_update_scheduler.sv */
// Deadline-ordered update scheduler with a table of SLOTS entries.
// Command channel: a word is taken at a clock edge where start is high and
// busy is low. func selects add, remove, hint (scale and needed) or tick.
// Results leave on valid, one cycle each; the receiver cannot stall them.
// Add, remove and hint give one acknowledgement with last set, built in the
// S_ACK state after the command is taken and registered to the outputs.
// A tick walks the due entries in deadline order, lowest slot on ties. The
// entries sit in a row of cells, and each search passes the best candidate
// down the row one cell per cycle. A dispatched entry adds interval
// arithmetic in S_CALC1 and S_CALC2, a dropped entry none. A dispatch is
// held and shown when the next dispatch reaches S_CALC2 or a search ends
// with no due entry left, so the last one can carry last.
// A tick with nothing to dispatch gives no result.
// Reset frees every slot; entry contents are written by add before use.
module deadline_update_scheduler
    import dus_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [4:0]  entry_id,
    input  logic [31:0] now_time,
    input  logic [15:0] min_interval,
    input  logic [15:0] max_interval,
    input  logic [9:0]  scale,
    input  logic        needed,
    output logic        valid,
    output logic        kind,
    output logic [4:0]  slot_out,
    output logic [15:0] elapsed_ms,
    output logic [15:0] next_interval,
    output logic [1:0]  status,
    output logic        last
);

    localparam int IDW = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic pend_reg, pend_next;
    logic valid_reg, valid_next;

    logic [1:0]  func_reg, func_next;
    logic [4:0]  id_reg, id_next;
    logic [31:0] now_reg, now_next;
    logic [15:0] min_reg, min_next, max_reg, max_next;
    logic [9:0]  scale_reg, scale_next;
    logic        need_reg, need_next;

    logic [IDW-1:0] win_id_reg, win_id_next;
    logic [31:0] win_last_reg, win_last_next;
    logic [15:0] win_min_reg, win_min_next, win_max_reg, win_max_next;
    logic [9:0]  win_scale_reg, win_scale_next;

    logic [15:0] lo_reg, lo_next, hi_reg, hi_next;
    logic        inv_reg, inv_next;
    logic [25:0] prod_reg, prod_next;
    logic [15:0] el_reg, el_next;

    logic [IDW-1:0] pend_id_reg, pend_id_next;
    logic [15:0] pend_el_reg, pend_el_next, pend_iv_reg, pend_iv_next;

    logic        kind_reg, kind_next;
    logic [4:0]  slot_reg, slot_next;
    logic [15:0] elo_reg, elo_next, ivo_reg, ivo_next;
    logic [1:0]  st_reg, st_next;
    logic        lastf_reg, lastf_next;

    upd_t           upd;
    logic [IDW-1:0] upd_id;
    cand_t          ch [SLOTS+1];
    logic [IDW-1:0] chid [SLOTS+1];
    logic [SLOTS-1:0] used_vec;

    logic [IDW-1:0] id_ix;
    logic        in_range;
    logic [16:0] hi_full;
    logic [31:0] el_raw;
    logic [15:0] cap;
    logic [18:0] vsum;
    logic [15:0] iv;

    assign ch[0]   = '0;
    assign chid[0] = '0;

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        dus_cell #(.IDW(IDW), .IDX(k)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .now    (now_reg),
            .upd    (upd),
            .upd_id (upd_id),
            .cin    (ch[k]),
            .cin_id (chid[k]),
            .cout   (ch[k+1]),
            .cout_id(chid[k+1]),
            .used   (used_vec[k])
        );
    end

    assign id_ix    = IDW'(id_reg);
    assign in_range = (32'(id_reg) < SLOTS);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        valid_next = 1'b0;
        func_next  = func_reg;
        id_next    = id_reg;
        now_next   = now_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        scale_next = scale_reg;
        need_next  = need_reg;
        win_id_next    = win_id_reg;
        win_last_next  = win_last_reg;
        win_min_next   = win_min_reg;
        win_max_next   = win_max_reg;
        win_scale_next = win_scale_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        inv_next  = inv_reg;
        prod_next = prod_reg;
        el_next   = el_reg;
        pend_id_next = pend_id_reg;
        pend_el_next = pend_el_reg;
        pend_iv_next = pend_iv_reg;
        kind_next  = kind_reg;
        slot_next  = slot_reg;
        elo_next   = elo_reg;
        ivo_next   = ivo_reg;
        st_next    = st_reg;
        lastf_next = lastf_reg;
        upd        = '0;
        upd.op     = UPD_NONE;
        upd_id     = '0;

        hi_full = (17'(BASE_MS) + 17'(win_max_reg)) >> 1;
        el_raw  = now_reg - win_last_reg;
        cap     = (win_max_reg > BASE_MS) ? win_max_reg : BASE_MS;
        vsum    = 19'(lo_reg) + 19'(prod_reg >> 8);
        iv      = inv_reg ? hi_reg
                : ((vsum > 19'(hi_reg)) ? hi_reg : vsum[15:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    id_next    = entry_id;
                    now_next   = now_time;
                    min_next   = min_interval;
                    max_next   = max_interval;
                    scale_next = scale;
                    need_next  = needed;
                    if (func == F_TICK)
                    begin
                        upd.op     = UPD_CLR;
                        pend_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_ACK;
                    end
                end
            end
            S_ACK:
            begin
                st_next = ST_OK;
                upd_id  = id_ix;
                upd.deadline = now_reg;
                upd.last_run = now_reg;
                upd.min_ms   = min_reg;
                upd.max_ms   = max_reg;
                upd.scale    = scale_reg;
                upd.wanted   = need_reg;
                if (!in_range)
                begin
                    st_next = ST_ABSENT;
                end
                else if (func_reg == F_ADD)
                begin
                    if (used_vec[id_ix])
                        st_next = ST_USED;
                    else
                        upd.op = UPD_ADD;
                end
                else if (!used_vec[id_ix])
                begin
                    st_next = ST_ABSENT;
                end
                else if (func_reg == F_REM)
                begin
                    upd.op = UPD_FREE;
                end
                else
                begin
                    upd.op = UPD_HINT;
                end
                valid_next = 1'b1;
                kind_next  = KIND_ACK;
                slot_next  = id_reg;
                elo_next   = '0;
                ivo_next   = '0;
                lastf_next = 1'b1;
                state_next = S_IDLE;
            end
            S_SEARCH:
            begin
                if (cnt_reg != CW'(SLOTS))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!ch[SLOTS].vld)
                begin
                    if (pend_reg)
                    begin
                        valid_next = 1'b1;
                        kind_next  = KIND_DISP;
                        slot_next  = 5'(pend_id_reg);
                        elo_next   = pend_el_reg;
                        ivo_next   = pend_iv_reg;
                        st_next    = ST_OK;
                        lastf_next = 1'b1;
                    end
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (!ch[SLOTS].wanted)
                begin
                    upd.op   = UPD_DROP;
                    upd_id   = chid[SLOTS];
                    cnt_next = '0;
                end
                else
                begin
                    win_id_next    = chid[SLOTS];
                    win_last_next  = ch[SLOTS].last_run;
                    win_min_next   = ch[SLOTS].min_ms;
                    win_max_next   = ch[SLOTS].max_ms;
                    win_scale_next = ch[SLOTS].scale;
                    state_next     = S_CALC1;
                end
            end
            S_CALC1:
            begin
                lo_next   = (win_min_reg > LO_FLOOR) ? win_min_reg : LO_FLOOR;
                hi_next   = hi_full[15:0];
                inv_next  = (hi_full[15:0] < lo_next);
                prod_next = 26'(hi_full[15:0] - lo_next) * 26'(win_scale_reg);
                if (el_raw == 32'd0)
                    el_next = 16'd1;
                else if (el_raw > 32'(cap))
                    el_next = cap;
                else
                    el_next = el_raw[15:0];
                state_next = S_CALC2;
            end
            S_CALC2:
            begin
                upd.op       = UPD_FIRE;
                upd_id       = win_id_reg;
                upd.deadline = now_reg + 32'(iv);
                upd.last_run = now_reg;
                if (pend_reg)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_DISP;
                    slot_next  = 5'(pend_id_reg);
                    elo_next   = pend_el_reg;
                    ivo_next   = pend_iv_reg;
                    st_next    = ST_OK;
                    lastf_next = 1'b0;
                end
                pend_next    = 1'b1;
                pend_id_next = win_id_reg;
                pend_el_next = el_reg;
                pend_iv_next = iv;
                cnt_next     = '0;
                state_next   = S_SEARCH;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        id_reg    <= id_next;
        now_reg   <= now_next;
        min_reg   <= min_next;
        max_reg   <= max_next;
        scale_reg <= scale_next;
        need_reg  <= need_next;
        win_id_reg    <= win_id_next;
        win_last_reg  <= win_last_next;
        win_min_reg   <= win_min_next;
        win_max_reg   <= win_max_next;
        win_scale_reg <= win_scale_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        inv_reg  <= inv_next;
        prod_reg <= prod_next;
        el_reg   <= el_next;
        pend_id_reg <= pend_id_next;
        pend_el_reg <= pend_el_next;
        pend_iv_reg <= pend_iv_next;
        kind_reg  <= kind_next;
        slot_reg  <= slot_next;
        elo_reg   <= elo_next;
        ivo_reg   <= ivo_next;
        st_reg    <= st_next;
        lastf_reg <= lastf_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign valid         = valid_reg;
    assign kind          = kind_reg;
    assign slot_out      = slot_reg;
    assign elapsed_ms    = elo_reg;
    assign next_interval = ivo_reg;
    assign status        = st_reg;
    assign last          = lastf_reg;

    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_ACK |-> last)
        else $error("acknowledgement without last");

    a_disp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_DISP |-> status == ST_OK && elapsed_ms != 16'd0)
        else $error("dispatch with bad status or zero elapsed time");

    a_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("result without work in progress");

    a_fire_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CALC2 |=> pend_reg)
        else $error("dispatch not held for output");

endmodule

/* verif/tb_deadline_update_scheduler.sv */
`timescale 1ns / 1ps

module tb_deadline_update_scheduler;
    import dus_pkg::*;

    localparam int NSLOT = 32;
    localparam int STALL_LIMIT = 6000;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  id;
        logic [31:0] now;
        logic [15:0] tmin;
        logic [15:0] tmax;
        logic [9:0]  sc;
        logic        nd;
        logic        drain;
    } cmd_word_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  slot;
        logic [15:0] elapsed;
        logic [15:0] interval;
        logic [1:0]  status;
        logic        last;
    } result_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [4:0]  entry_id;
    logic [31:0] now_time;
    logic [15:0] min_interval;
    logic [15:0] max_interval;
    logic [9:0]  scale;
    logic        needed;
    logic        valid;
    logic        kind;
    logic [4:0]  slot_out;
    logic [15:0] elapsed_ms;
    logic [15:0] next_interval;
    logic [1:0]  status;
    logic        last;

    deadline_update_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .entry_id(entry_id), .now_time(now_time),
        .min_interval(min_interval), .max_interval(max_interval),
        .scale(scale), .needed(needed), .valid(valid), .kind(kind),
        .slot_out(slot_out), .elapsed_ms(elapsed_ms),
        .next_interval(next_interval), .status(status), .last(last)
    );

    // Predictor state for the entry table.
    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_deadline [NSLOT];
    logic [31:0] tbl_last_run [NSLOT];
    logic [15:0] tbl_min [NSLOT];
    logic [15:0] tbl_max [NSLOT];
    logic [9:0]  tbl_scale [NSLOT];
    logic        tbl_wanted [NSLOT];

    cmd_word_t    pending_cmds[$];
    result_word_t expected_results[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           stim_done = 0;
    logic [31:0]  clock_ms = 0;

    initial clk = 0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_cmd(input cmd_word_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic queue_result(input result_word_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic logic [15:0] pick_interval(int s);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] v;
        lo = (tbl_min[s] > 30) ? tbl_min[s] : 32'd30;
        hi = (32'd1000 + tbl_max[s]) >> 1;
        if (hi < lo)
            return hi[15:0];
        v = lo + (((hi - lo) * tbl_scale[s]) >> 8);
        return (v > hi) ? hi[15:0] : v[15:0];
    endfunction

    task automatic predict_schedule(input cmd_word_t c);
        logic [1:0]   st;
        bit           fired [NSLOT];
        int           best;
        int           n;
        logic [31:0]  cap;
        logic [31:0]  el;
        logic [15:0]  iv;
        result_word_t r;
        if (c.func != F_TICK) begin
            st = ST_OK;
            if (c.func == F_ADD) begin
                if (tbl_valid[c.id])
                    st = ST_USED;
                else
                begin
                    tbl_valid[c.id] = 1;
                    tbl_deadline[c.id] = c.now;
                    tbl_last_run[c.id] = c.now;
                    tbl_min[c.id] = c.tmin;
                    tbl_max[c.id] = c.tmax;
                    tbl_scale[c.id] = c.sc;
                    tbl_wanted[c.id] = c.nd;
                end
            end
            else if (!tbl_valid[c.id])
                st = ST_ABSENT;
            else if (c.func == F_REM)
                tbl_valid[c.id] = 0;
            else
            begin
                tbl_scale[c.id] = c.sc;
                tbl_wanted[c.id] = c.nd;
            end
            r = {KIND_ACK, c.id, 16'd0, 16'd0, st, 1'b1};
            queue_result(r);
            return;
        end
        foreach (fired[i]) fired[i] = 0;
        n = 0;
        forever
        begin
            best = -1;
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!tbl_valid[i] || fired[i] || !(tbl_deadline[i] < c.now))
                    continue;
                if (best < 0 || tbl_deadline[i] < tbl_deadline[best])
                    best = i;
            end
            if (best < 0)
                break;
            fired[best] = 1;
            if (!tbl_wanted[best])
            begin
                tbl_valid[best] = 0;
                continue;
            end
            cap = (tbl_max[best] > 1000) ? tbl_max[best] : 32'd1000;
            el = c.now - tbl_last_run[best];
            if (el < 1)
                el = 1;
            if (el > cap)
                el = cap;
            iv = pick_interval(best);
            tbl_deadline[best] = c.now + iv;
            tbl_last_run[best] = c.now;
            r = {KIND_DISP, 5'(best), el[15:0], iv, ST_OK, 1'b0};
            queue_result(r);
            n++;
        end
        if (n > 0)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    function automatic cmd_word_t make_cmd(logic [1:0] f, logic [4:0] id, logic [31:0] now,
                                           logic [15:0] tmin, logic [15:0] tmax,
                                           logic [9:0] sc, logic nd);
        return {f, id, now, tmin, tmax, sc, nd, 1'b0};
    endfunction

    // Driver: waits a random gap per word and, for a word marked drain, for the results to drain.
    int gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            func <= F_ADD;
            entry_id <= 0;
            now_time <= 0;
            min_interval <= 0;
            max_interval <= 0;
            scale <= 0;
            needed <= 0;
            gap <= 0;
        end
        else if (start && !busy)
        begin
            predict_schedule(pending_cmds.pop_front());
            start <= 0;
            gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        end
        else if (!start && pending_cmds.size() > 0)
        begin
            if (gap > 0)
                gap <= gap - 1;
            else if (!pending_cmds[0].drain || expected_results.size() == 0)
            begin
                func <= pending_cmds[0].func;
                entry_id <= pending_cmds[0].id;
                now_time <= pending_cmds[0].now;
                min_interval <= pending_cmds[0].tmin;
                max_interval <= pending_cmds[0].tmax;
                scale <= pending_cmds[0].sc;
                needed <= pending_cmds[0].nd;
                start <= 1;
            end
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result slot %0d", slot_out));
            else
            begin
                result_word_t e;
                e = expected_results.pop_front();
                if (kind !== e.kind || slot_out !== e.slot || elapsed_ms !== e.elapsed ||
                    next_interval !== e.interval || status !== e.status || last !== e.last)
                    report_mismatch($sformatf(
                        "got k%0d s%0d e%0d i%0d st%0d l%0d, want k%0d s%0d e%0d i%0d st%0d l%0d",
                        kind, slot_out, elapsed_ms, next_interval, status, last,
                        e.kind, e.slot, e.elapsed, e.interval, e.status, e.last));
            end
        end
    end

    // Watchdog on cycles with no accepted word in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !stim_done)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_random_cmd();
        int r;
        cmd_word_t c;
        r = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 900);
        c = make_cmd(F_TICK, 5'($urandom), clock_ms, 16'($urandom_range(0, 1200)),
                     16'($urandom_range(0, 2500)), 10'($urandom), 1'($urandom_range(0, 4) != 0));
        if ($urandom_range(0, 9) == 0)
        begin
            c.tmin = 16'($urandom);
            c.tmax = 16'($urandom);
        end
        if ($urandom_range(0, 19) == 0)
            c.now = $urandom;
        if (r < 40)
            c.func = F_ADD;
        else if (r < 50)
            c.func = F_REM;
        else if (r < 65)
            c.func = F_HINT;
        queue_cmd(c);
    endtask

    initial
    begin
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // Directed: extremes, every function and each special case.
        queue_cmd(make_cmd(F_REM, 5'd3, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(F_HINT, 5'd3, 0, 0, 0, 10'h3ff, 1));
        queue_cmd(make_cmd(F_TICK, 5'd0, 32'd5, 0, 0, 0, 0));
        queue_cmd(make_cmd(F_ADD, 5'd0, 32'd100, 16'd0, 16'd0, 10'd0, 1));
        queue_cmd(make_cmd(F_ADD, 5'd31, 32'd100, 16'hffff, 16'hffff, 10'h3ff, 1));
        queue_cmd(make_cmd(F_ADD, 5'd31, 32'd7, 0, 0, 0, 0));
        queue_cmd(make_cmd(F_ADD, 5'd5, 32'd100, 16'd40, 16'd3000, 10'd128, 1));
        queue_cmd(make_cmd(F_ADD, 5'd6, 32'd90, 16'd2000, 16'd10, 10'd512, 1));
        queue_cmd(make_cmd(F_ADD, 5'd7, 32'd90, 16'd0, 16'd0, 10'd0, 0));
        queue_cmd(make_cmd(F_ADD, 5'd8, 32'hfffffff0, 16'd100, 16'd900, 10'd300, 1));
        queue_cmd(make_cmd(F_TICK, 5'd0, 32'd100, 0, 0, 0, 0));
        queue_cmd(make_cmd(F_TICK, 5'd0, 32'd101, 0, 0, 0, 0));
        queue_cmd(make_cmd(F_TICK, 5'd0, 32'hffffffff, 0, 0, 0, 0));
        queue_cmd(make_cmd(F_HINT, 5'd5, 0, 0, 0, 10'd0, 0));
        queue_cmd(make_cmd(F_REM, 5'd0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(F_TICK, 5'd0, 32'hffffffff, 0, 0, 0, 0));
        for (int i = 0; i < NSLOT; i++)
            queue_cmd(make_cmd(F_ADD, 5'(i), 32'd50 + (i % 3), 16'($urandom),
                               16'($urandom), 10'($urandom), 1));
        queue_cmd(make_cmd(F_TICK, 5'd0, 32'd60000, 0, 0, 0, 0));
        for (int i = 0; i < NSLOT; i++)
            queue_cmd(make_cmd(F_REM, 5'(i), 0, 0, 0, 0, 0));
        pending_cmds[pending_cmds.size() - 1].drain = 1;

        clock_ms = 1000;
        for (int k = 0; k < 200; k++)
        begin
            add_random_cmd();
            if (k == 100)
                pending_cmds[pending_cmds.size() - 1].drain = 1;
        end

        wait (pending_cmds.size() == 0 && !start);
        stim_done = 1;
        for (int w = 0; w < 20000 && expected_results.size() != 0; w++)
            @(posedge clk);
        repeat (1200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* sim.f */
hdl/dus_pkg.sv
hdl/dus_cell.sv
hdl/deadline_update_scheduler.sv
verif/tb_deadline_update_scheduler.sv
